// ----- design/ray_box_slab_intersect_macros.svh -----
// Assertion macros shared by the ray/box slab test design
`ifndef RAY_BOX_SLAB_INTERSECT_MACROS_SVH
`define RAY_BOX_SLAB_INTERSECT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define RBSI_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define RBSI_ASSERT_NXT(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error(msg);

`endif

// ----- design/rbsi_pkg.sv -----
// Shared constants and types for the ray/box slab test
package rbsi_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  // quotient bits below the saturation limit
  localparam int QBITS       = COORD_WIDTH - 1;
  // dividend bits that are known zero quotient-wise before the first step
  localparam int PRE_SHIFT   = COORD_WIDTH - 1 - FRAC_BITS;
  // divider: prep, init, one stage per quotient bit, final
  localparam int DIV_STAGES  = QBITS + 3;
  // after the divider: axis order, cross-axis reduce, hit/output
  localparam int NSTG        = DIV_STAGES + 3;
  localparam int NAXES       = 3;
  localparam int NDIV        = 2 * NAXES;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

endpackage

// ----- design/rbsi_if.sv -----
// Valid/ready channel interfaces for ray items and slab results
interface rbsi_ray_if import rbsi_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t origin_x;
  coord_t origin_y;
  coord_t origin_z;
  coord_t direction_x;
  coord_t direction_y;
  coord_t direction_z;
  coord_t box_min_x;
  coord_t box_min_y;
  coord_t box_min_z;
  coord_t box_max_x;
  coord_t box_max_y;
  coord_t box_max_z;

  modport source (
    output valid, origin_x, origin_y, origin_z, direction_x, direction_y, direction_z,
           box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, origin_z, direction_x, direction_y, direction_z,
           box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    output ready
  );
endinterface

interface rbsi_result_if import rbsi_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t entry_distance;
  coord_t exit_distance;
  logic   hit;

  modport source (output valid, entry_distance, exit_distance, hit, input ready);
  modport sink (input valid, entry_distance, exit_distance, hit, output ready);
endinterface

// ----- design/rbsi_divider.sv -----
// Pipelined saturating fixed-point divider: (plane - origin) * 2^FRAC_BITS / dir
module rbsi_divider import rbsi_pkg::*; (
  input  logic                  clk,
  input  logic [DIV_STAGES-1:0] ld,
  input  coord_t                plane,
  input  coord_t                origin,
  input  coord_t                dir,
  output coord_t                quot
);

  localparam int UW = COORD_WIDTH + 1;
  localparam int LS = QBITS + 1;   // last step stage

  logic signed [UW-1:0]    diff;
  logic [UW-1:0]           un   [0:LS];
  logic [COORD_WIDTH-1:0]  ud   [0:LS];
  logic                    neg  [0:LS];
  logic                    nz   [0:LS];
  logic                    ovf  [1:LS];
  logic [COORD_WIDTH-1:0]  rem  [1:LS];
  logic [QBITS-1:0]        q    [1:LS];
  logic                    ovf0;

  // numerator with one guard bit
  assign diff = {plane[COORD_WIDTH-1], plane} - {origin[COORD_WIDTH-1], origin};

  // prep: split into magnitudes and sign
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      un[0]  <= diff[UW-1] ? UW'(-diff) : UW'(diff);
      ud[0]  <= dir[COORD_WIDTH-1] ? COORD_WIDTH'(-dir) : COORD_WIDTH'(dir);
      neg[0] <= diff[UW-1] ^ dir[COORD_WIDTH-1];
      nz[0]  <= (diff != '0);
    end
  end

  // init: saturation check, seed remainder with the high dividend bits
  assign ovf0 = ({{PRE_SHIFT{1'b0}}, un[0]} >= {1'b0, ud[0], {PRE_SHIFT{1'b0}}});

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      un[1]  <= un[0];
      ud[1]  <= ud[0];
      neg[1] <= neg[0];
      nz[1]  <= nz[0];
      ovf[1] <= ovf0;
      rem[1] <= COORD_WIDTH'(un[0] >> PRE_SHIFT);
      q[1]   <= '0;
    end
  end

  // one restoring step per stage, quotient MSB first
  for (genvar s = 2; s <= LS; s++) begin : g_step
    localparam int BI = LS - s;
    logic                   nb;
    logic [COORD_WIDTH:0]   trial;
    logic                   ge;

    if (BI >= FRAC_BITS) begin : g_bit
      assign nb = un[s-1][BI-FRAC_BITS];
    end else begin : g_zero
      assign nb = 1'b0;
    end

    assign trial = {rem[s-1], nb};
    assign ge    = (trial >= {1'b0, ud[s-1]});

    always_ff @(posedge clk) begin
      if (ld[s]) begin
        un[s]  <= un[s-1];
        ud[s]  <= ud[s-1];
        neg[s] <= neg[s-1];
        nz[s]  <= nz[s-1];
        ovf[s] <= ovf[s-1];
        rem[s] <= ge ? COORD_WIDTH'(trial - {1'b0, ud[s-1]}) : COORD_WIDTH'(trial);
        q[s]   <= {q[s-1][QBITS-2:0], ge};
      end
    end
  end

  // final: apply sign and saturate
  always_ff @(posedge clk) begin
    if (ld[DIV_STAGES-1]) begin
      if (!nz[LS]) begin
        quot <= '0;
      end else if (neg[LS]) begin
        quot <= ovf[LS] ? COORD_MIN : -coord_t'({1'b0, q[LS]});
      end else begin
        quot <= ovf[LS] ? COORD_MAX : coord_t'({1'b0, q[LS]});
      end
    end
  end

endmodule

// ----- design/ray_box_slab_intersect.sv -----
// Ray versus axis-aligned box slab test, top level
//
// Channels: ray (sink) carries origin, direction and box corners in signed
// Q16.16; result (source) carries entry_distance, exit_distance and hit.
// A transaction completes on a rising edge with valid and ready both high.
// Throughput: one ray per cycle, no gaps, while result.ready is high.
// Pipeline: each ray passes six parallel divider pipelines that resolve
// one quotient bit per stage (31 bits), plus prep, seed and sign stages,
// then three stages that order per axis, reduce across axes and form hit.
// Reset (rst, synchronous) empties every stage; payload is left as is.
// When the receiver stalls, each stage holds while the one after it is
// full and stalled; empty stages keep filling, so up to 37 rays are held
// before ray.ready drops. No transaction is lost or repeated.
`include "ray_box_slab_intersect_macros.svh"

module ray_box_slab_intersect import rbsi_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  rbsi_ray_if.sink     ray,
  rbsi_result_if.source result
);

  logic [NSTG-1:0]  vld;
  logic [NSTG-1:0]  rdy;
  coord_t           o   [NAXES];
  coord_t           d   [NAXES];
  coord_t           lo  [NAXES];
  coord_t           hi  [NAXES];
  coord_t           tq  [NDIV];
  logic [NAXES-1:0] par   [DIV_STAGES];
  logic [NAXES-1:0] pmiss [DIV_STAGES];
  coord_t           ax_in  [NAXES];
  coord_t           ax_out [NAXES];
  logic             miss_a;
  coord_t           entry_r;
  coord_t           exit_r;
  coord_t           entry01;
  coord_t           exit01;
  logic             miss_r;
  coord_t           out_entry;
  coord_t           out_exit;
  logic             out_hit;

  assign o[0]  = ray.origin_x;     assign o[1]  = ray.origin_y;     assign o[2]  = ray.origin_z;
  assign d[0]  = ray.direction_x;  assign d[1]  = ray.direction_y;  assign d[2]  = ray.direction_z;
  assign lo[0] = ray.box_min_x;    assign lo[1] = ray.box_min_y;    assign lo[2] = ray.box_min_z;
  assign hi[0] = ray.box_max_x;    assign hi[1] = ray.box_max_y;    assign hi[2] = ray.box_max_z;

  // stage handshake: a stage takes new data when empty or when it drains
  assign rdy[NSTG-1] = !vld[NSTG-1] || result.ready;
  for (genvar k = 0; k < NSTG-1; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end
  assign ray.ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= ray.valid;
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // six dividers, two planes per axis
  for (genvar a = 0; a < NAXES; a++) begin : g_axis
    rbsi_divider u_div_lo (
      .clk(clk), .ld(rdy[DIV_STAGES-1:0]),
      .plane(lo[a]), .origin(o[a]), .dir(d[a]), .quot(tq[2*a])
    );
    rbsi_divider u_div_hi (
      .clk(clk), .ld(rdy[DIV_STAGES-1:0]),
      .plane(hi[a]), .origin(o[a]), .dir(d[a]), .quot(tq[2*a+1])
    );
  end

  // classify parallel axes on entry, carry the flags beside the dividers
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int a = 0; a < NAXES; a++) begin
        par[0][a]   <= (d[a] == '0);
        pmiss[0][a] <= (d[a] == '0) &&
                       !((o[a] >= lo[a] && o[a] <= hi[a]) || (o[a] >= hi[a] && o[a] <= lo[a]));
      end
    end
    for (int k = 1; k < DIV_STAGES; k++) begin
      if (rdy[k]) begin
        par[k]   <= par[k-1];
        pmiss[k] <= pmiss[k-1];
      end
    end
  end

  // order each axis pair, substitute parallel-axis limits
  always_ff @(posedge clk) begin
    if (rdy[DIV_STAGES]) begin
      for (int a = 0; a < NAXES; a++) begin
        if (pmiss[DIV_STAGES-1][a]) begin
          ax_in[a]  <= COORD_MAX;
          ax_out[a] <= COORD_MIN;
        end else if (par[DIV_STAGES-1][a]) begin
          ax_in[a]  <= COORD_MIN;
          ax_out[a] <= COORD_MAX;
        end else if (tq[2*a] < tq[2*a+1]) begin
          ax_in[a]  <= tq[2*a];
          ax_out[a] <= tq[2*a+1];
        end else begin
          ax_in[a]  <= tq[2*a+1];
          ax_out[a] <= tq[2*a];
        end
      end
      miss_a <= |pmiss[DIV_STAGES-1];
    end
  end

  // reduce across axes
  assign entry01 = (ax_in[1] > ax_in[0]) ? ax_in[1] : ax_in[0];
  assign exit01  = (ax_out[1] < ax_out[0]) ? ax_out[1] : ax_out[0];

  always_ff @(posedge clk) begin
    if (rdy[DIV_STAGES+1]) begin
      entry_r <= (ax_in[2] > entry01) ? ax_in[2] : entry01;
      exit_r  <= (ax_out[2] < exit01) ? ax_out[2] : exit01;
      miss_r  <= miss_a;
    end
  end

  // form hit and hold the result; keep the compare signed
  always_ff @(posedge clk) begin
    if (rdy[NSTG-1]) begin
      out_entry <= entry_r;
      out_exit  <= exit_r;
      out_hit   <= !miss_r && (exit_r >= ((entry_r > 0) ? entry_r : coord_t'(0)));
    end
  end

  assign result.valid          = vld[NSTG-1];
  assign result.entry_distance = out_entry;
  assign result.exit_distance  = out_exit;
  assign result.hit            = out_hit;

  `RBSI_ASSERT_IMP(a_hit_exit_ahead, clk, rst, result.valid && result.hit, result.exit_distance >= result.entry_distance, "hit with exit before entry")
  `RBSI_ASSERT_IMP(a_hit_exit_pos, clk, rst, result.valid && result.hit, result.exit_distance >= 0, "hit with negative exit")
  `RBSI_ASSERT_NXT(a_reduce_hold, clk, rst, vld[NSTG-2] && !rdy[NSTG-1], vld[NSTG-2] && $stable(entry_r) && $stable(exit_r), "reduce stage lost data under stall")
  `RBSI_ASSERT_IMP(a_block_full, clk, rst, !ray.ready, vld[0] && vld[NSTG-1], "input blocked with room in pipeline")

endmodule

// ----- verif/tb_ray_box_slab_intersect.sv -----
// Testbench for the ray/box slab test: directed and random rays checked against a predictor
`timescale 1ns / 100ps

module tb_ray_box_slab_intersect;
  import rbsi_pkg::*;

  typedef struct packed {
    coord_t entry_distance;
    coord_t exit_distance;
    logic   hit;
  } slab_result_t;

  typedef struct {
    coord_t o[3];
    coord_t d[3];
    coord_t lo[3];
    coord_t hi[3];
  } ray_item_t;

  logic clk;
  logic rst;
  rbsi_ray_if    ray();
  rbsi_result_if result();

  ray_box_slab_intersect DUT (.clk(clk), .rst(rst), .ray(ray), .result(result));

  slab_result_t expected_hits[$];
  int  errors;
  bit  src_idle_on;
  bit  snk_idle_on;
  bit  long_hold;

  // clock: 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Divide n * 2^FRAC_BITS by d, truncate toward zero, saturate
  function automatic longint slab_div(longint n, longint d);
    longint q;
    longint lim;
    logic signed [127:0] wide;
    lim = longint'(1) <<< (COORD_WIDTH - 1);
    if (n == 0) return 0;
    wide = (128'(signed'(n)) <<< FRAC_BITS) / 128'(signed'(d));
    if (wide > 128'(lim - 1)) q = lim - 1;
    else if (wide < -128'(lim)) q = -lim;
    else q = longint'(wide);
    return q;
  endfunction

  // Compute entry, exit and hit for one ray
  function automatic slab_result_t slab_predict(ray_item_t it);
    slab_result_t r;
    longint entry, ex, o, d, lo, hi, t1, t2, ai, ao, pmin, pmax;
    bit miss;
    entry = longint'(COORD_MIN);
    ex    = longint'(COORD_MAX);
    miss  = 1'b0;
    for (int a = 0; a < 3; a++) begin
      o = it.o[a]; d = it.d[a]; lo = it.lo[a]; hi = it.hi[a];
      if (d == 0) begin
        pmin = (lo < hi) ? lo : hi;
        pmax = (lo < hi) ? hi : lo;
        if (o >= pmin && o <= pmax) continue;
        miss = 1'b1;
        ai = longint'(COORD_MAX);
        ao = longint'(COORD_MIN);
      end else begin
        t1 = slab_div(lo - o, d);
        t2 = slab_div(hi - o, d);
        ai = (t1 < t2) ? t1 : t2;
        ao = (t1 < t2) ? t2 : t1;
      end
      if (ai > entry) entry = ai;
      if (ao < ex) ex = ao;
    end
    r.entry_distance = coord_t'(entry);
    r.exit_distance  = coord_t'(ex);
    r.hit = !miss && (ex >= ((entry > 0) ? entry : 0));
    return r;
  endfunction

  // Offer one ray and hold until the transaction; valid stays up for the next ray
  task automatic send_ray(ray_item_t it);
    int gap;
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      ray.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ray.valid       <= 1'b1;
    ray.origin_x    <= it.o[0];  ray.origin_y    <= it.o[1];  ray.origin_z    <= it.o[2];
    ray.direction_x <= it.d[0];  ray.direction_y <= it.d[1];  ray.direction_z <= it.d[2];
    ray.box_min_x   <= it.lo[0]; ray.box_min_y   <= it.lo[1]; ray.box_min_z   <= it.lo[2];
    ray.box_max_x   <= it.hi[0]; ray.box_max_y   <= it.hi[1]; ray.box_max_z   <= it.hi[2];
    do @(posedge clk); while (!ray.ready);
    expected_hits.push_back(slab_predict(it));
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 6))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return 0;
      3: return coord_t'($urandom_range(0, 32'h7ffff)) - coord_t'(32'h40000);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic ray_item_t rand_ray();
    ray_item_t it;
    for (int a = 0; a < 3; a++) begin
      it.o[a] = rand_coord();
      it.d[a] = ($urandom_range(0, 7) == 0) ? coord_t'(0) : rand_coord();
      it.lo[a] = rand_coord();
      it.hi[a] = rand_coord();
    end
    return it;
  endfunction

  // Well-formed ray: box around small coordinates, origin nearby aiming at the box centre
  function automatic ray_item_t aimed_ray();
    ray_item_t it;
    coord_t c;
    for (int a = 0; a < 3; a++) begin
      c = coord_t'($urandom_range(0, 32'h3ffff)) - coord_t'(32'h20000);
      it.lo[a] = c - coord_t'($urandom_range(1, 32'h30000));
      it.hi[a] = c + coord_t'($urandom_range(1, 32'h30000));
      it.o[a]  = coord_t'($urandom_range(0, 32'hfffff)) - coord_t'(32'h80000);
      it.d[a]  = ($urandom_range(0, 9) == 0) ? coord_t'(0)
                 : coord_t'((c - it.o[a]) >>> $urandom_range(0, 8));
      if (it.d[a] == 0 && $urandom_range(0, 1)) it.o[a] = c;
    end
    return it;
  endfunction

  function automatic ray_item_t make_ray(coord_t o, coord_t d, coord_t lo, coord_t hi);
    ray_item_t it;
    for (int a = 0; a < 3; a++) begin
      it.o[a] = o; it.d[a] = d; it.lo[a] = lo; it.hi[a] = hi;
    end
    return it;
  endfunction

  // Drop valid and wait until every expected result has come
  task automatic wait_drain();
    ray.valid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    ray_item_t it;
    send_ray(make_ray(0, 32'h10000, 32'h10000, 32'h20000));
    send_ray(make_ray(0, 32'hffff0000, 32'h10000, 32'h20000));
    send_ray(make_ray(0, 0, 32'hffff0000, 32'h10000));   // parallel, inside
    send_ray(make_ray(0, 0, 32'h10000, 32'h20000));      // parallel, outside
    send_ray(make_ray(0, 0, 32'h10000, 32'hffff0000));   // parallel, inverted box
    send_ray(make_ray(32'h8000, 32'h10000, 32'h20000, 32'h10000)); // inverted box
    send_ray(make_ray(COORD_MIN, 1, COORD_MAX, COORD_MAX));        // saturate positive
    send_ray(make_ray(COORD_MAX, 1, COORD_MIN, COORD_MIN));        // saturate negative
    send_ray(make_ray(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN));
    send_ray(make_ray(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    send_ray(make_ray(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
    send_ray(make_ray(32'h30000, 32'h10000, 32'h10000, 32'h20000)); // box behind
    send_ray(make_ray(32'h10000, 32'h10000, 32'h10000, 32'h10000)); // touching
    send_ray(make_ray(-1, -1, 0, 0));
    it = make_ray(0, 32'h10000, 32'h10000, 32'h20000);
    it.d[1] = 0; it.lo[1] = 32'h40000; it.hi[1] = 32'h50000;        // one axis miss
    send_ray(it);
    it = make_ray(0, 32'h10000, 32'hffff0000, 32'h10000);           // origin inside
    send_ray(it);
    it = make_ray(0, 32'h10000, 32'h10000, 32'h20000);
    it.lo[2] = 32'h30000; it.hi[2] = 32'h40000;                     // slabs disjoint
    send_ray(it);
    send_ray(make_ray(32'h55555555, 32'haaaaaaaa, 32'h12345678, 32'hedcba987));
    send_ray(make_ray(32'haaaaaaaa, 32'h55555555, 32'hedcba987, 32'h12345678));
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++)
      send_ray(($urandom_range(0, 3) == 0) ? rand_ray() : aimed_ray());
  endtask

  // Long receiver hold while rays keep coming, then pause until drained
  task automatic test_backpressure();
    long_hold = 1'b1;
    src_idle_on = 1'b0;
    test_random(60);
    long_hold = 1'b0;
    wait_drain();
    src_idle_on = 1'b1;
  endtask

  // Receiver ready: random bursts of stall, long hold on request
  initial begin
    int cnt;
    result.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        result.ready <= 1'b0;
        for (cnt = 0; cnt < 200; cnt++) @(posedge clk);
        result.ready <= 1'b1;
        while (long_hold) @(posedge clk);
      end else if (snk_idle_on && $urandom_range(0, 5) == 0) begin
        result.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        result.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    slab_result_t exp_r;
    if (!rst && result.valid && result.ready) begin
      if (expected_hits.size() == 0) begin
        $display("%0t: unexpected result entry=%h exit=%h hit=%b", $time,
                 result.entry_distance, result.exit_distance, result.hit);
        errors++;
      end else begin
        exp_r = expected_hits.pop_front();
        if (exp_r.entry_distance !== result.entry_distance) begin
          $display("%0t: entry_distance expected %h actual %h", $time,
                   exp_r.entry_distance, result.entry_distance);
          errors++;
        end
        if (exp_r.exit_distance !== result.exit_distance) begin
          $display("%0t: exit_distance expected %h actual %h", $time,
                   exp_r.exit_distance, result.exit_distance);
          errors++;
        end
        if (exp_r.hit !== result.hit) begin
          $display("%0t: hit expected %b actual %b", $time, exp_r.hit, result.hit);
          errors++;
        end
      end
    end
  end

  initial begin
    errors = 0;
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    long_hold = 1'b0;
    rst = 1'b1;
    ray.valid = 1'b0;
    {ray.origin_x, ray.origin_y, ray.origin_z} = '0;
    {ray.direction_x, ray.direction_y, ray.direction_z} = '0;
    {ray.box_min_x, ray.box_min_y, ray.box_min_z} = '0;
    {ray.box_max_x, ray.box_max_y, ray.box_max_z} = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(400);
    test_backpressure();
    test_random(330);
    // last part: no idling on either side
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    test_random(140);
    wait_drain();
    repeat (60) @(posedge clk);
    if (errors == 0 && expected_hits.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Timeout
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
